// ===== src/iset_pkg.sv =====
// ----------------------------------------------------------------------------
// iset_pkg: shared types and constants for the interval set table
// Entry, request, response and cell command types used by the cell chain.
// ----------------------------------------------------------------------------
package iset_pkg;

  localparam int unsigned MAX_INTERVALS = 64;
  localparam int unsigned COORD_BITS    = 32;
  localparam int unsigned CNT_W         = $clog2(MAX_INTERVALS + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CNT_W-1:0]      count_t;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_QUERY  = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    coord_t     left;
    coord_t     right;
  } iset_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       covered;
    count_t     entry_count;
  } iset_rsp_t;

  typedef struct packed {
    coord_t base;   // inclusive start
    coord_t limit;  // exclusive end
  } iset_entry_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_COLLAPSE,
    OP_INSERT,
    OP_MERGE,
    OP_DELETE,
    OP_SPLIT,
    OP_TRIM
  } iset_op_e;

  typedef struct packed {
    iset_op_e op;
    logic     rm;     // remove compares (strict on both sides)
    coord_t   left;
    coord_t   right;
  } iset_cmd_t;

  typedef struct packed {
    logic below;   // entry lies wholly before the range
    logic is_lo;   // first entry not below
    logic hit;     // entry overlaps (or touches, for add) the range
    logic inner;   // entry wholly inside the range
    logic cov;     // entry covers the range
    logic split;   // entry strictly contains the range on both sides
  } iset_flags_t;

endpackage

// ===== src/iset_cell.sv =====
// ----------------------------------------------------------------------------
// iset_cell: one slot of the interval chain
// Holds one entry, classifies it against the current range and moves data
// to or from its neighbors as the broadcast command asks.
// ----------------------------------------------------------------------------
module iset_cell import iset_pkg::*; (
  input  logic        clk_i,
  input  iset_cmd_t   cmd_i,
  input  logic        valid_i,
  input  iset_flags_t prev_flags_i,
  input  iset_entry_t prev_entry_i,
  input  iset_entry_t next_entry_i,
  output iset_entry_t entry_o,
  output iset_flags_t flags_o
);

  iset_entry_t entry_q, entry_d;
  iset_flags_t fl;
  logic        at_or_past_l;

  always_comb begin
    fl.below = valid_i & (cmd_i.rm ? (entry_q.limit <= cmd_i.left)
                                   : (entry_q.limit <  cmd_i.left));
    fl.is_lo = ~fl.below & prev_flags_i.below;
    fl.hit   = valid_i & ~fl.below & (cmd_i.rm ? (entry_q.base <  cmd_i.right)
                                               : (entry_q.base <= cmd_i.right));
    at_or_past_l = entry_q.base >= cmd_i.left;
    fl.inner = fl.hit & at_or_past_l & (entry_q.limit <= cmd_i.right);
    fl.cov   = valid_i & ~at_or_past_l | valid_i & (entry_q.base == cmd_i.left);
    fl.cov   = fl.cov & (entry_q.limit >= cmd_i.right);
    fl.split = fl.hit & (entry_q.base < cmd_i.left) & (entry_q.limit > cmd_i.right);
  end

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i.op)
      OP_COLLAPSE: begin
        if (fl.is_lo) entry_d.limit = next_entry_i.limit;
        else if (!prev_flags_i.below) entry_d = next_entry_i;
      end
      OP_INSERT: begin
        if (fl.is_lo) begin
          entry_d.base  = cmd_i.left;
          entry_d.limit = cmd_i.right;
        end else if (!prev_flags_i.below) begin
          entry_d = prev_entry_i;
        end
      end
      OP_MERGE: begin
        if (fl.hit) begin
          if (cmd_i.left < entry_q.base) entry_d.base = cmd_i.left;
          if (cmd_i.right > entry_q.limit) entry_d.limit = cmd_i.right;
        end
      end
      OP_DELETE: begin
        if (at_or_past_l) entry_d = next_entry_i;
      end
      OP_SPLIT: begin
        if (fl.is_lo) begin
          entry_d.limit = cmd_i.left;
        end else if (prev_flags_i.is_lo) begin
          entry_d.base  = cmd_i.right;
          entry_d.limit = prev_entry_i.limit;
        end else if (!prev_flags_i.below) begin
          entry_d = prev_entry_i;
        end
      end
      OP_TRIM: begin
        if (fl.hit && (entry_q.base < cmd_i.left)) entry_d.limit = cmd_i.left;
        if (fl.hit && (entry_q.limit > cmd_i.right)) entry_d.base = cmd_i.right;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign flags_o = fl;

endmodule

// ===== src/interval_set_table.sv =====
// ----------------------------------------------------------------------------
// interval_set_table: sorted table of disjoint half-open intervals
// Add, remove and query of [left,right) over a chain of entry cells.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high while busy_o is low; its one result
// appears on rsp_o for exactly one cycle with done_o high, and the receiver
// cannot stall it. busy_o stays high from the cycle after acceptance until
// the result cycle, so a new item can be taken in the result cycle itself.
// Queries, unused codes and empty or reversed ranges finish in a single
// step. An add takes one step per extra entry it swallows, then a final
// merge, insert or full-table step; a remove takes one step per entry it
// deletes outright, then a final split, trim or full-table step. Each step
// is one move of the cell chain: every cell compares its entry to the range
// in parallel and shifts one place toward its neighbor. Full-table errors
// leave the table untouched.
// ----------------------------------------------------------------------------
module interval_set_table import iset_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  iset_req_t req_i,
  output logic      busy_o,
  output logic      done_o,
  output iset_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  state_e      state_q, state_d;
  iset_req_t   req_q;
  count_t      count_q, count_d;
  logic        done_q, done_d;
  iset_rsp_t   rsp_q, rsp_d;
  iset_cmd_t   cmd;

  iset_entry_t entry  [MAX_INTERVALS];
  iset_flags_t flags  [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] hit_v, inner_v, cov_v, split_v;
  logic [MAX_INTERVALS-2:0] pair_v;

  logic full;
  assign full = (count_q == count_t'(MAX_INTERVALS));

  // Row of cells; cell 0 sees a virtual predecessor that lies below the range.
  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    iset_flags_t pf;
    iset_entry_t pe, ne;
    if (i == 0) begin : g_first
      assign pf = '{below: 1'b1, default: 1'b0};
      assign pe = '0;
    end else begin : g_mid
      assign pf = flags[i-1];
      assign pe = entry[i-1];
    end
    if (i == MAX_INTERVALS - 1) begin : g_last
      assign ne = '0;
    end else begin : g_nxt
      assign ne = entry[i+1];
      assign pair_v[i] = flags[i].hit & flags[i+1].hit;
    end

    iset_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .valid_i      (count_t'(i) < count_q),
      .prev_flags_i (pf),
      .prev_entry_i (pe),
      .next_entry_i (ne),
      .entry_o      (entry[i]),
      .flags_o      (flags[i])
    );

    assign hit_v[i]   = flags[i].hit;
    assign inner_v[i] = flags[i].inner;
    assign cov_v[i]   = flags[i].cov;
    assign split_v[i] = flags[i].split;
  end

  // One step per cycle while running; finishing registers the result.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    cmd.op    = OP_HOLD;
    cmd.rm    = (req_q.func == FUNC_REMOVE);
    cmd.left  = req_q.left;
    cmd.right = req_q.right;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_RUN;
      end
      S_RUN: begin
        logic finish;
        logic [1:0] st;
        logic cv;
        finish = 1'b1;
        st     = ST_OK;
        cv     = 1'b0;
        priority if (req_q.func == FUNC_UNUSED) begin
          st = ST_OK;
        end else if (req_q.left >= req_q.right) begin
          st = ST_RANGE;
        end else if (req_q.func == FUNC_QUERY) begin
          cv = |cov_v;
        end else if (req_q.func == FUNC_ADD) begin
          priority if (|pair_v) begin
            cmd.op  = OP_COLLAPSE;
            count_d = count_q - count_t'(1);
            finish  = 1'b0;
          end else if (|hit_v) begin
            cmd.op = OP_MERGE;
          end else if (full) begin
            st = ST_FULL;
          end else begin
            cmd.op  = OP_INSERT;
            count_d = count_q + count_t'(1);
          end
        end else begin
          priority if (|inner_v) begin
            cmd.op  = OP_DELETE;
            count_d = count_q - count_t'(1);
            finish  = 1'b0;
          end else if (|split_v) begin
            if (full) begin
              st = ST_FULL;
            end else begin
              cmd.op  = OP_SPLIT;
              count_d = count_q + count_t'(1);
            end
          end else begin
            cmd.op = OP_TRIM;
          end
        end
        if (finish) begin
          state_d           = S_IDLE;
          done_d            = 1'b1;
          rsp_d.status      = st;
          rsp_d.covered     = cv;
          rsp_d.entry_count = count_d;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == S_IDLE) req_q <= req_i;
    rsp_q <= rsp_d;
  end

  assign busy_o = (state_q == S_RUN);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== tb/sv/interval_set_table_test.sv =====
// ----------------------------------------------------------------------------
// interval_set_table_test: self-checking bench for the interval set table
// Directed table of adds, removes and queries (edges, full table, bad ranges,
// unused code), then random traffic checked against a behavioral table.
// ----------------------------------------------------------------------------
module interval_set_table_test;
  import iset_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DIR_ROWS = 22;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  iset_req_t req_i = '0;
  logic      busy_o;
  logic      done_o;
  iset_rsp_t rsp_o;

  interval_set_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #2 clk_i = ~clk_i;

  // behavioral copy of the table: sorted, disjoint, never touching
  coord_t      span_lo[$];
  coord_t      span_hi[$];
  iset_rsp_t   pending_rsp[$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Directed rows; chk set means the typed expectation is compared too.
  typedef struct packed {
    logic [1:0] func;
    coord_t     left;
    coord_t     right;
    logic       chk;
    logic [1:0] status;
    logic       covered;
    count_t     count;
  } dir_row_t;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{FUNC_QUERY,  32'd0,   32'd1,          1'b1, ST_OK,    1'b0, 7'd0},
    '{FUNC_REMOVE, 32'd0,   32'hFFFF_FFFF,  1'b1, ST_OK,    1'b0, 7'd0},
    '{FUNC_ADD,    32'd5,   32'd5,          1'b1, ST_RANGE, 1'b0, 7'd0},
    '{FUNC_QUERY,  32'd9,   32'd3,          1'b1, ST_RANGE, 1'b0, 7'd0},
    '{FUNC_REMOVE, 32'hFFFF_FFFF, 32'd0,    1'b1, ST_RANGE, 1'b0, 7'd0},
    '{FUNC_UNUSED, 32'd1,   32'd2,          1'b1, ST_OK,    1'b0, 7'd0},
    '{FUNC_ADD,    32'd0,   32'd10,         1'b1, ST_OK,    1'b0, 7'd1},
    '{FUNC_ADD,    32'd10,  32'd20,         1'b1, ST_OK,    1'b0, 7'd1},
    '{FUNC_QUERY,  32'd0,   32'd20,         1'b1, ST_OK,    1'b1, 7'd1},
    '{FUNC_QUERY,  32'd0,   32'd21,         1'b1, ST_OK,    1'b0, 7'd1},
    '{FUNC_REMOVE, 32'd5,   32'd7,          1'b1, ST_OK,    1'b0, 7'd2},
    '{FUNC_ADD,    32'd30,  32'd40,         1'b0, ST_OK,    1'b0, 7'd0},
    '{FUNC_ADD,    32'd50,  32'd60,         1'b0, ST_OK,    1'b0, 7'd0},
    '{FUNC_ADD,    32'd15,  32'd55,         1'b0, ST_OK,    1'b0, 7'd0},
    '{FUNC_REMOVE, 32'd0,   32'd3,          1'b0, ST_OK,    1'b0, 7'd0},
    '{FUNC_REMOVE, 32'd58,  32'd100,        1'b0, ST_OK,    1'b0, 7'd0},
    '{FUNC_ADD,    32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0, ST_OK, 1'b0, 7'd0},
    '{FUNC_QUERY,  32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0, ST_OK, 1'b0, 7'd0},
    '{FUNC_ADD,    32'd0,   32'hFFFF_FFFF,  1'b0, ST_OK,    1'b0, 7'd0},
    '{FUNC_QUERY,  32'd1,   32'hFFFF_FFFE,  1'b0, ST_OK,    1'b0, 7'd0},
    '{FUNC_REMOVE, 32'd0,   32'hFFFF_FFFF,  1'b1, ST_OK,    1'b0, 7'd0},
    '{FUNC_QUERY,  32'h5555_5555, 32'hAAAA_AAAA, 1'b1, ST_OK, 1'b0, 7'd0}
  };

  // Applies one operation to the behavioral table and returns its response.
  function automatic iset_rsp_t apply_op(iset_req_t rq);
    iset_rsp_t  rs;
    int         lo, hi, n, k;
    coord_t     ns, ne;
    coord_t     piece_lo[$];
    coord_t     piece_hi[$];
    rs = '0;
    n = span_lo.size();
    if (rq.func == FUNC_UNUSED) begin
      // ignored
    end else if (rq.left >= rq.right) begin
      rs.status = ST_RANGE;
    end else if (rq.func == FUNC_QUERY) begin
      for (k = 0; k < n && span_lo[k] <= rq.left; k++)
        if (span_hi[k] >= rq.right) rs.covered = 1'b1;
    end else if (rq.func == FUNC_ADD) begin
      // add merges touching entries too
      lo = 0;
      while (lo < n && span_hi[lo] < rq.left) lo++;
      hi = lo;
      while (hi < n && span_lo[hi] <= rq.right) hi++;
      if (hi == lo && n >= MAX_INTERVALS) begin
        rs.status = ST_FULL;
      end else begin
        ns = rq.left;
        ne = rq.right;
        if (hi > lo) begin
          if (span_lo[lo] < ns) ns = span_lo[lo];
          if (span_hi[hi-1] > ne) ne = span_hi[hi-1];
        end
        for (k = lo; k < hi; k++) begin
          span_lo.delete(lo);
          span_hi.delete(lo);
        end
        span_lo.insert(lo, ns);
        span_hi.insert(lo, ne);
      end
    end else begin
      lo = 0;
      while (lo < n && span_hi[lo] <= rq.left) lo++;
      hi = lo;
      while (hi < n && span_lo[hi] < rq.right) hi++;
      if (hi > lo) begin
        if (span_lo[lo] < rq.left) begin
          piece_lo.push_back(span_lo[lo]);
          piece_hi.push_back(rq.left);
        end
        if (span_hi[hi-1] > rq.right) begin
          piece_lo.push_back(rq.right);
          piece_hi.push_back(span_hi[hi-1]);
        end
        if (n + piece_lo.size() - (hi - lo) > MAX_INTERVALS) begin
          rs.status = ST_FULL;
        end else begin
          for (k = lo; k < hi; k++) begin
            span_lo.delete(lo);
            span_hi.delete(lo);
          end
          for (k = piece_lo.size() - 1; k >= 0; k--) begin
            span_lo.insert(lo, piece_lo[k]);
            span_hi.insert(lo, piece_hi[k]);
          end
        end
      end
    end
    rs.entry_count = count_t'(span_lo.size());
    return rs;
  endfunction

  // Drives one item and waits for its acceptance edge.
  task automatic send_item(iset_req_t rq);
    start_i <= 1'b1;
    req_i   <= rq;
    do @(posedge clk_i); while (busy_o);
    pending_rsp.push_back(apply_op(rq));
  endtask

  task automatic sender_gap();
    int unsigned g;
    g = $urandom_range(1, 6);
    start_i <= 1'b0;
    repeat (g) @(posedge clk_i);
  endtask

  // Random coordinate: mostly a narrow window so ranges collide often,
  // sometimes anywhere, sometimes at the edges.
  function automatic coord_t pick_coord(int unsigned wide);
    case ($urandom_range(0, 9))
      0:       return coord_t'($urandom);
      1:       return $urandom_range(0, 1) ? '0 : '1;
      default: return coord_t'($urandom_range(0, wide));
    endcase
  endfunction

  // Result monitor: results are sampled at the edge that ends the strobe.
  always @(posedge clk_i) begin
    iset_rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $error("result with nothing expected: %p", rsp_o);
        err_cnt++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp_o.status !== exp_rsp.status) begin
          $error("status: expected %0d actual %0d", exp_rsp.status, rsp_o.status);
          err_cnt++;
        end
        if (rsp_o.covered !== exp_rsp.covered) begin
          $error("covered: expected %0d actual %0d", exp_rsp.covered, rsp_o.covered);
          err_cnt++;
        end
        if (rsp_o.entry_count !== exp_rsp.entry_count) begin
          $error("entry_count: expected %0d actual %0d",
                 exp_rsp.entry_count, rsp_o.entry_count);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: ends the run with FAIL once LIMIT_CYCLES is passed.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    iset_req_t   rq;
    iset_rsp_t   typed_rsp;
    int unsigned wide;
    int unsigned i;
    int unsigned idx;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part; typed expectations are cross-checked against the table
    for (idx = 0; idx < DIR_ROWS; idx++) begin
      rq.func  = dir_tab[idx].func;
      rq.left  = dir_tab[idx].left;
      rq.right = dir_tab[idx].right;
      send_item(rq);
      typed_rsp = pending_rsp[$];
      if (dir_tab[idx].chk &&
          (typed_rsp.status != dir_tab[idx].status ||
           typed_rsp.covered != dir_tab[idx].covered ||
           typed_rsp.entry_count != dir_tab[idx].count)) begin
        $error("row %0d: typed expectation disagrees with table", idx);
        err_cnt++;
      end
    end

    // fill to capacity with separated spans, then force full-table errors, then a merge and a trim
    for (i = 0; i < MAX_INTERVALS; i++) begin
      rq = '{FUNC_ADD, coord_t'(1000 + 10 * i), coord_t'(1005 + 10 * i)};
      send_item(rq);
    end
    send_item('{FUNC_ADD, coord_t'(1007), coord_t'(1008)});
    send_item('{FUNC_REMOVE, coord_t'(1001), coord_t'(1002)});
    send_item('{FUNC_ADD, coord_t'(1005), coord_t'(1010)});
    send_item('{FUNC_REMOVE, coord_t'(0), coord_t'(1007)});

    // random part: windows widen and shrink to keep the table lively
    for (i = 0; i < 500; i++) begin
      wide = (i % 100 < 50) ? 400 : 4000;
      rq.func  = ($urandom_range(0, 19) == 0) ? FUNC_UNUSED
               : 2'($urandom_range(0, 2));
      rq.left  = pick_coord(wide);
      rq.right = ($urandom_range(0, 7) == 0) ? pick_coord(wide)
               : rq.left + coord_t'($urandom_range(1, 40));
      send_item(rq);
      if (i < 420 && $urandom_range(0, 3) == 0) sender_gap();
    end
    start_i <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (MAX_INTERVALS + 8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
